// ----- src/obc_pkg.sv -----
// ----------------------------------------------------------------------------
// obc_pkg
// Shared types and constants for the online bipartite check block.
// ----------------------------------------------------------------------------
package obc_pkg;

    localparam int MAX_NODES  = 1024;
    localparam int NODE_W     = $clog2(MAX_NODES);
    localparam int FIELD_W    = 10;
    localparam int COUNT_BITS = 16;
    localparam int ANSWER_W   = 16;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    typedef struct packed {
        logic [FIELD_W-1:0] node_a;
        logic [FIELD_W-1:0] node_b;
    } t_in_item;

    typedef struct packed {
        logic                still_bipartite;
        logic                conflict_now;
        logic [ANSWER_W-1:0] answer;
    } t_out_item;

    // one entry of the forest table
    typedef struct packed {
        logic [NODE_W-1:0] parent;
        logic              parity;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // per-edge verdict from the walker to the tally
    typedef struct packed {
        logic done;
        logic odd_cycle;
    } t_find_res;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK_A,
        ST_WALK_B,
        ST_DONE
    } t_state;

endpackage

// ----- src/obc_ram.sv -----
// ----------------------------------------------------------------------------
// obc_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module obc_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [DATA_W-1:0]        i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [DATA_W-1:0]        o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/obc_walker.sv -----
// ----------------------------------------------------------------------------
// obc_walker
// Parity union-find engine: clears the forest table after reset, walks both
// endpoints of an edge to their roots one table read per cycle, then links
// the roots if they differ, or flags an odd cycle on equal roots and parities.
// ----------------------------------------------------------------------------
module obc_walker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  obc_pkg::t_in_item i_in_item,
    input  logic              i_out_free,
    output obc_pkg::t_find_res o_res
);

    obc_pkg::t_state r_state, n_state;

    logic [obc_pkg::NODE_W-1:0] r_clr_idx, n_clr_idx;
    logic [obc_pkg::NODE_W-1:0] r_node_b, n_node_b;
    logic [obc_pkg::NODE_W-1:0] r_cur, n_cur;
    logic                       r_acc, n_acc;
    logic [obc_pkg::NODE_W-1:0] r_root_a, n_root_a;
    logic                       r_par_a, n_par_a;
    logic [obc_pkg::NODE_W-1:0] r_root_b, n_root_b;
    logic                       r_par_b, n_par_b;

    logic                       ram_we;
    logic [obc_pkg::NODE_W-1:0] ram_waddr;
    obc_pkg::t_entry            ram_wdata;
    logic [obc_pkg::NODE_W-1:0] ram_raddr;
    logic [obc_pkg::ENTRY_W-1:0] ram_rdata;
    obc_pkg::t_entry            rd_entry;
    logic                       root_hit;
    logic                       clr_last;

    assign rd_entry = obc_pkg::t_entry'(ram_rdata);
    assign root_hit = (rd_entry.parent == r_cur);
    assign clr_last = (r_clr_idx == obc_pkg::NODE_W'(obc_pkg::MAX_NODES - 1));

    obc_ram #(
        .DATA_W (obc_pkg::ENTRY_W),
        .DEPTH  (obc_pkg::MAX_NODES)
    ) u_forest (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            obc_pkg::ST_CLEAR: begin
                if (clr_last) begin
                    n_state = obc_pkg::ST_IDLE;
                end
            end
            obc_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = obc_pkg::ST_WALK_A;
                end
            end
            obc_pkg::ST_WALK_A: begin
                if (root_hit) begin
                    n_state = obc_pkg::ST_WALK_B;
                end
            end
            obc_pkg::ST_WALK_B: begin
                if (root_hit) begin
                    n_state = obc_pkg::ST_DONE;
                end
            end
            obc_pkg::ST_DONE: begin
                if (i_out_free) begin
                    n_state = obc_pkg::ST_IDLE;
                end
            end
            default: n_state = obc_pkg::ST_CLEAR;
        endcase
    end

    // outputs and datapath
    always_comb begin
        o_in_stall = 1'b1;
        o_res      = '0;
        ram_we     = 1'b0;
        ram_waddr  = r_root_a;
        ram_wdata  = '{parent: r_root_b, parity: r_par_a ^ r_par_b ^ 1'b1};
        ram_raddr  = r_cur;
        n_clr_idx  = r_clr_idx;
        n_node_b   = r_node_b;
        n_cur      = r_cur;
        n_acc      = r_acc;
        n_root_a   = r_root_a;
        n_par_a    = r_par_a;
        n_root_b   = r_root_b;
        n_par_b    = r_par_b;
        case (r_state)
            obc_pkg::ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr_idx;
                ram_wdata = '{parent: r_clr_idx, parity: 1'b0};
                n_clr_idx = r_clr_idx + 1'b1;
            end
            obc_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
                ram_raddr  = obc_pkg::NODE_W'(i_in_item.node_a);
                n_cur      = obc_pkg::NODE_W'(i_in_item.node_a);
                n_node_b   = obc_pkg::NODE_W'(i_in_item.node_b);
                n_acc      = 1'b0;
            end
            obc_pkg::ST_WALK_A: begin
                if (root_hit) begin
                    n_root_a  = r_cur;
                    n_par_a   = r_acc;
                    ram_raddr = r_node_b;
                    n_cur     = r_node_b;
                    n_acc     = 1'b0;
                end else begin
                    ram_raddr = rd_entry.parent;
                    n_cur     = rd_entry.parent;
                    n_acc     = r_acc ^ rd_entry.parity;
                end
            end
            obc_pkg::ST_WALK_B: begin
                if (root_hit) begin
                    n_root_b = r_cur;
                    n_par_b  = r_acc;
                end else begin
                    ram_raddr = rd_entry.parent;
                    n_cur     = rd_entry.parent;
                    n_acc     = r_acc ^ rd_entry.parity;
                end
            end
            obc_pkg::ST_DONE: begin
                if (i_out_free) begin
                    ram_we          = (r_root_a != r_root_b);
                    o_res.done      = 1'b1;
                    o_res.odd_cycle = (r_root_a == r_root_b) && (r_par_a == r_par_b);
                end
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= obc_pkg::ST_CLEAR;
            r_clr_idx <= '0;
        end else begin
            r_state   <= n_state;
            r_clr_idx <= n_clr_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_node_b <= n_node_b;
        r_cur    <= n_cur;
        r_acc    <= n_acc;
        r_root_a <= n_root_a;
        r_par_a  <= n_par_a;
        r_root_b <= n_root_b;
        r_par_b  <= n_par_b;
    end

endmodule

// ----- src/online_bipartite_check_top.sv -----
// ----------------------------------------------------------------------------
// online_bipartite_check_top
// Incremental bipartiteness check over a stream of undirected edges.
//
// Input channel: one edge (node_a, node_b) per item, valid/stall handshake.
// Output channel: one result per edge: still_bipartite, conflict_now and
// answer (edges before the first odd cycle, else edges so far, saturating).
//
// After reset the forest table is cleared, one entry per cycle, all 1024
// entries; o_in_stall stays high during that pass.
// An edge is accepted in the idle state, then each endpoint is walked to its
// root (walk A, then walk B); each step of a root walk is one read of the
// single forest RAM. The done state then waits for the output register, links
// the roots if they differ and loads the result. The next edge can be accepted
// the cycle after the result is loaded. The result sits in an output register;
// a new edge is accepted and walked while it waits, and the engine holds before
// linking until the register is free, so a stalled receiver holds the block
// at most one edge ahead.
// ----------------------------------------------------------------------------
module online_bipartite_check_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  obc_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output obc_pkg::t_out_item o_out_item
);

    obc_pkg::t_find_res res;
    logic               out_free;

    logic                           r_out_valid, n_out_valid;
    obc_pkg::t_out_item             r_out_item, n_out_item;
    logic [obc_pkg::COUNT_BITS-1:0] r_count, n_count;
    logic [obc_pkg::COUNT_BITS-1:0] r_first, n_first;
    logic                           r_seen, n_seen;
    logic                           now_hit;

    assign out_free = !r_out_valid || !i_out_stall;

    obc_walker u_walker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (i_in_item),
        .i_out_free (out_free),
        .o_res      (res)
    );

    always_comb begin
        n_out_valid = r_out_valid && i_out_stall;
        n_out_item  = r_out_item;
        n_count     = r_count;
        n_first     = r_first;
        n_seen      = r_seen;
        now_hit     = res.odd_cycle && !r_seen;
        if (res.done) begin
            n_seen  = r_seen || res.odd_cycle;
            n_first = now_hit ? r_count : r_first;
            n_count = (r_count != obc_pkg::COUNT_MAX) ? r_count + 1'b1 : r_count;
            n_out_valid                = 1'b1;
            n_out_item.still_bipartite = !n_seen;
            n_out_item.conflict_now    = now_hit;
            n_out_item.answer          = n_seen ? obc_pkg::ANSWER_W'(n_first)
                                                : obc_pkg::ANSWER_W'(n_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_count     <= '0;
            r_first     <= '0;
            r_seen      <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            r_count     <= n_count;
            r_first     <= n_first;
            r_seen      <= n_seen;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_item <= n_out_item;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

// ----- tb/obc_tb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obc_tb_pkg
// Scoreboard for the online bipartite check: a parity union-find forest that
// tracks every accepted edge and holds the verdicts still owed by the block.
// ----------------------------------------------------------------------------
package obc_tb_pkg;

    import obc_pkg::*;

    class bipartite_board;
        logic [NODE_W-1:0]     up_link   [MAX_NODES];
        logic                  up_parity [MAX_NODES];
        logic [COUNT_BITS-1:0] edge_total;
        logic                  odd_seen;
        logic [COUNT_BITS-1:0] odd_index;
        t_out_item             verdicts[$];
        int                    failures;

        function new();
            for (int i = 0; i < MAX_NODES; i++) begin
                up_link[i]   = NODE_W'(i);
                up_parity[i] = 1'b0;
            end
            edge_total = '0;
            odd_seen   = 1'b0;
            odd_index  = '0;
            failures   = 0;
        endfunction

        // walk to the root, xor of parities along the way
        function void find_root(input logic [NODE_W-1:0] node,
                                output logic [NODE_W-1:0] root, output logic par);
            logic [NODE_W-1:0] cur;
            logic              acc;
            cur = node;
            acc = 1'b0;
            for (int steps = 0; steps < MAX_NODES; steps++) begin
                if (up_link[cur] == cur) break;
                acc = acc ^ up_parity[cur];
                cur = up_link[cur];
            end
            root = cur;
            par  = acc;
        endfunction

        function void note_edge(t_in_item it);
            logic [NODE_W-1:0] na, nb, ra, rb;
            logic              pa, pb, first;
            t_out_item         res;
            na    = NODE_W'(32'(it.node_a) % MAX_NODES);
            nb    = NODE_W'(32'(it.node_b) % MAX_NODES);
            first = 1'b0;
            find_root(na, ra, pa);
            find_root(nb, rb, pb);
            if (ra != rb) begin
                up_link[ra]   = rb;
                up_parity[ra] = pa ^ pb ^ 1'b1;
            end else if (pa == pb && !odd_seen) begin
                odd_seen  = 1'b1;
                odd_index = edge_total;
                first     = 1'b1;
            end
            if (edge_total != COUNT_MAX) edge_total++;
            res.still_bipartite = !odd_seen;
            res.conflict_now    = first;
            res.answer          = ANSWER_W'(odd_seen ? odd_index : edge_total);
            verdicts.insert(verdicts.size(), res);
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                $error("%s: expected %0d, actual %0d", name, want, got);
                failures++;
            end
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (verdicts.size() == 0) begin
                $error("result with none pending: answer %0d", got.answer);
                failures++;
                return;
            end
            want = verdicts.pop_front();
            compare_field("still_bipartite", want.still_bipartite, got.still_bipartite);
            compare_field("conflict_now", want.conflict_now, got.conflict_now);
            compare_field("answer", want.answer, got.answer);
        endfunction
    endclass

endpackage

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench for online_bipartite_check_top. Directed edges build an even
// graph, random edges that keep a fixed two-coloring follow under several
// idle/stall mixes, then odd cycles, self-loops and unconstrained random
// edges. Results are checked in order against the scoreboard's own parity
// forest.
// ----------------------------------------------------------------------------
module tb;

    import obc_pkg::*;
    import obc_tb_pkg::*;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_item  in_item   = '0;
    logic      out_stall = 1'b0;
    logic      in_stall;
    logic      out_valid;
    t_out_item out_item;

    int idle_pct  = 0;
    int stall_pct = 0;

    bipartite_board board;

    online_bipartite_check_top u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk) begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) board.check_result(out_item);
    end

    task automatic send_edge(input logic [FIELD_W-1:0] a, input logic [FIELD_W-1:0] b);
        t_in_item it;
        it.node_a = a;
        it.node_b = b;
        while ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        board.note_edge(it);
    endtask

    // keep_even: both ends get opposite colors under xor-of-bits coloring
    task automatic random_edges(input bit keep_even, input int count);
        logic [FIELD_W-1:0] a, b;
        for (int i = 0; i < count; i++) begin
            a = FIELD_W'(($urandom_range(9) < 6) ? $urandom_range(63) : $urandom_range(1023));
            b = FIELD_W'(($urandom_range(9) < 6) ? $urandom_range(63) : $urandom_range(1023));
            if (keep_even) begin
                if (^a == ^b) b[0] = ~b[0];
            end else if ($urandom_range(9) == 0) begin
                b = a;
            end
            send_edge(a, b);
        end
    endtask

    task automatic random_phases(input bit keep_even);
        int sender_mix [4] = '{0, 86, 0, 37};
        int stall_mix  [4] = '{0, 0, 86, 37};
        for (int p = 0; p < 4; p++) begin
            idle_pct  = sender_mix[p];
            stall_pct = stall_mix[p];
            random_edges(keep_even, 100);
        end
        idle_pct  = 0;
        stall_pct = 0;
    endtask

    initial begin
        board = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // even graph: extremes, repeat, even square, tree joins
        send_edge(10'd0, 10'd1022);
        send_edge(10'd1023, 10'd1);
        send_edge(10'd1022, 10'd0);
        send_edge(10'd1023, 10'd2);
        send_edge(10'd3, 10'd4);
        send_edge(10'd4, 10'd5);
        send_edge(10'd5, 10'd7);
        send_edge(10'd7, 10'd3);
        send_edge(10'd1, 10'd3);
        send_edge(10'd1022, 10'd1023);

        random_phases(1'b1);

        // triangle closes the first odd cycle; later ones are not flagged
        send_edge(10'd8, 10'd9);
        send_edge(10'd9, 10'd10);
        send_edge(10'd10, 10'd8);
        send_edge(10'd0, 10'd0);
        send_edge(10'd1023, 10'd1023);
        send_edge(10'd3, 10'd5);

        random_phases(1'b0);
        in_valid <= 1'b0;

        while (board.verdicts.size() != 0) @(posedge clk);
        repeat (64) @(posedge clk);
        if (board.failures == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

    initial begin
        #200_000_000;
        $display("tb failed");
        $finish;
    end

endmodule
